// ----- src/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C byte-level bus master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned RegW     = 8;
  localparam logic [7:0]  PhaseTicksRst = 8'd14;
  localparam logic [7:0]  AckTimeoutRst = 8'd250;
  localparam logic [3:0]  BitsPerByte   = 4'd8;

  // configuration register indexes
  localparam logic CfgPhaseTicks = 1'b0;
  localparam logic CfgAckTimeout = 1'b1;

  typedef enum logic [1:0] {
    KindStart = 2'd0,
    KindSend  = 2'd1,
    KindRecv  = 2'd2,
    KindStop  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    PhIdle = 4'd0,
    PhStA  = 4'd1,
    PhStB  = 4'd2,
    PhStC  = 4'd3,
    PhSpA  = 4'd4,
    PhSpB  = 4'd5,
    PhTxA  = 4'd6,
    PhTxB  = 4'd7,
    PhTxC  = 4'd8,
    PhAkA  = 4'd9,
    PhAkB  = 4'd10,
    PhAkW  = 4'd11,
    PhAkD  = 4'd12,
    PhRxL  = 4'd13,
    PhRxH  = 4'd14,
    PhRaB  = 4'd15
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [7:0]  delay_count;
    logic [7:0]  wait_count;
    logic        scl;
    logic        sda;
    logic        ack_choice;
    logic [7:0]  received;
    logic        ack_status;
    logic        ack_drive;
  } seq_state_t;

  typedef struct packed {
    logic        cmd_valid;
    kind_e       kind;
    logic [7:0]  tx_byte;
    logic        send_ack;
    logic        sda_level;
  } tick_t;

  typedef struct packed {
    logic        scl_release;
    logic        sda_release;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  rx_byte;
    logic        status;
  } result_t;

endpackage

// ----- src/i2cm_seq.sv -----
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus phase sequencer: holds the SCL/SDA state and steps it once per tick.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  i2cm_pkg::tick_t    tick_i,
  input  logic [7:0]         phase_ticks_i,
  input  logic [7:0]         ack_timeout_i,
  output i2cm_pkg::result_t  res_o
);

  i2cm_pkg::seq_state_t st_q, st_d;
  logic                 done;
  logic [7:0]           pt;
  logic [8:0]           delay_inc;
  logic [3:0]           bit_inc;

  assign pt        = (phase_ticks_i == 8'd0) ? 8'd1 : phase_ticks_i;
  assign delay_inc = {1'b0, st_q.delay_count} + 9'd1;
  assign bit_inc   = st_q.bit_count + 4'd1;

  // next state
  always_comb begin
    st_d = st_q;
    done = 1'b0;
    if (st_q.phase == i2cm_pkg::PhIdle) begin
      if (tick_i.cmd_valid) begin
        st_d.ack_status  = 1'b0;
        st_d.wait_count  = '0;
        st_d.bit_count   = '0;
        st_d.ack_drive   = 1'b0;
        st_d.delay_count = '0;
        unique case (tick_i.kind)
          i2cm_pkg::KindStart: begin
            st_d.phase = i2cm_pkg::PhStA;
            st_d.scl   = 1'b1;
            st_d.sda   = 1'b1;
          end
          i2cm_pkg::KindSend: begin
            st_d.shift_reg = tick_i.tx_byte;
            st_d.phase     = i2cm_pkg::PhTxA;
            st_d.scl       = 1'b0;
            st_d.sda       = tick_i.tx_byte[7];
          end
          i2cm_pkg::KindRecv: begin
            st_d.received   = '0;
            st_d.ack_choice = tick_i.send_ack;
            st_d.phase      = i2cm_pkg::PhRxL;
            st_d.scl        = 1'b0;
            st_d.sda        = 1'b1;
          end
          default: begin
            st_d.phase = i2cm_pkg::PhSpA;
            st_d.scl   = 1'b0;
            st_d.sda   = 1'b0;
          end
        endcase
      end
    end else if (st_q.phase == i2cm_pkg::PhAkW) begin
      if (!tick_i.sda_level) begin
        st_d.phase       = i2cm_pkg::PhAkD;
        st_d.scl         = 1'b0;
        st_d.delay_count = '0;
      end else if (st_q.wait_count >= ack_timeout_i) begin
        // no acknowledge: finish with a stop condition
        st_d.ack_status  = 1'b1;
        st_d.phase       = i2cm_pkg::PhSpA;
        st_d.scl         = 1'b0;
        st_d.sda         = 1'b0;
        st_d.delay_count = '0;
      end else begin
        st_d.wait_count = st_q.wait_count + 8'd1;
      end
    end else begin
      if (st_q.phase == i2cm_pkg::PhRxH && st_q.delay_count == 8'd0) begin
        st_d.received = {st_q.received[6:0], tick_i.sda_level};
      end
      if (delay_inc >= {1'b0, pt}) begin
        st_d.delay_count = '0;
        unique case (st_q.phase)
          i2cm_pkg::PhStA: begin
            st_d.phase = i2cm_pkg::PhStB;
            st_d.sda   = 1'b0;
          end
          i2cm_pkg::PhStB: begin
            st_d.phase = i2cm_pkg::PhStC;
            st_d.scl   = 1'b0;
          end
          i2cm_pkg::PhSpA: begin
            st_d.phase = i2cm_pkg::PhSpB;
            st_d.scl   = 1'b1;
            st_d.sda   = 1'b1;
          end
          i2cm_pkg::PhTxA: begin
            st_d.phase = i2cm_pkg::PhTxB;
            st_d.scl   = 1'b1;
          end
          i2cm_pkg::PhTxB: begin
            st_d.shift_reg = {st_q.shift_reg[6:0], 1'b0};
            st_d.bit_count = bit_inc;
            st_d.phase     = i2cm_pkg::PhTxC;
            st_d.scl       = 1'b0;
            st_d.sda       = 1'b1;
          end
          i2cm_pkg::PhTxC: begin
            if (st_q.bit_count >= i2cm_pkg::BitsPerByte) begin
              st_d.phase = i2cm_pkg::PhAkA;
              st_d.sda   = 1'b1;
            end else begin
              st_d.phase = i2cm_pkg::PhTxA;
              st_d.scl   = 1'b0;
              st_d.sda   = st_q.shift_reg[7];
            end
          end
          i2cm_pkg::PhAkA: begin
            st_d.phase = i2cm_pkg::PhAkB;
            st_d.scl   = 1'b1;
          end
          i2cm_pkg::PhAkB: begin
            st_d.wait_count = '0;
            st_d.phase      = i2cm_pkg::PhAkW;
          end
          i2cm_pkg::PhRxL: begin
            st_d.scl = 1'b1;
            if (st_q.ack_drive) begin
              st_d.ack_drive = 1'b0;
              st_d.phase     = i2cm_pkg::PhRaB;
            end else begin
              st_d.phase = i2cm_pkg::PhRxH;
            end
          end
          i2cm_pkg::PhRxH: begin
            st_d.bit_count = bit_inc;
            st_d.phase     = i2cm_pkg::PhRxL;
            st_d.scl       = 1'b0;
            if (bit_inc >= i2cm_pkg::BitsPerByte) begin
              // ack slot: drive low for ACK, release for NACK
              st_d.ack_drive = 1'b1;
              st_d.sda       = ~st_q.ack_choice;
            end
          end
          i2cm_pkg::PhRaB: begin
            st_d.scl   = 1'b0;
            st_d.phase = i2cm_pkg::PhIdle;
            done       = 1'b1;
          end
          i2cm_pkg::PhStC, i2cm_pkg::PhSpB, i2cm_pkg::PhAkD: begin
            st_d.phase = i2cm_pkg::PhIdle;
            done       = 1'b1;
          end
          default: begin
            st_d.delay_count = st_q.delay_count;
          end
        endcase
      end else begin
        st_d.delay_count = delay_inc[7:0];
      end
    end
  end

  // result of this tick
  always_comb begin
    res_o.scl_release = st_d.scl;
    res_o.sda_release = st_d.sda;
    res_o.busy_res    = (st_d.phase != i2cm_pkg::PhIdle);
    res_o.done_res    = done;
    res_o.rx_byte     = st_d.received;
    res_o.status      = st_d.ack_status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase       <= i2cm_pkg::PhIdle;
      st_q.bit_count   <= '0;
      st_q.shift_reg   <= '0;
      st_q.delay_count <= '0;
      st_q.wait_count  <= '0;
      st_q.scl         <= 1'b1;
      st_q.sda         <= 1'b1;
      st_q.ack_choice  <= 1'b0;
      st_q.received    <= '0;
      st_q.ack_status  <= 1'b0;
      st_q.ack_drive   <= 1'b0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  a_ack_wait_scl_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == i2cm_pkg::PhAkW |-> st_q.scl)
    else $error("scl pulled low during ack wait");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |=> st_q.phase == i2cm_pkg::PhIdle)
    else $error("command done but sequencer not idle");

  a_tx_bits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == i2cm_pkg::PhTxA |-> st_q.bit_count < i2cm_pkg::BitsPerByte)
    else $error("send phase past last bit");

endmodule

// ----- src/i2c_bit_level_master.sv -----
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// I2C byte-level bus master with stream input/output and config write port.
// ----------------------------------------------------------------------------
// Each input transaction is one bus tick: an optional command (start, send
// byte with ack check, receive byte with ACK/NACK, stop) plus the sampled SDA
// level. Every tick yields exactly one output transaction with the SCL/SDA
// release levels, busy, a one-tick done pulse, the received byte and the
// no-ack status. One tick is taken per clock cycle while the output register
// is empty or read; the sequencer updates its state in the cycle a tick is
// accepted and the result sits in a single output register. Registers are to
// be written only while no command is running; the block does not enforce it.
module i2c_bit_level_master (
  input  logic         clk_i,
  input  logic         rst_ni,
  // cfg index 0 phase_ticks, 1 ack_timeout
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [7:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [0] cmd_valid, [8:1] tx_byte, [9] send_ack, [10] sda_level, [15:11] zero
  input  logic [15:0]  s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
  // [11:4] rx_byte, [12] status, [15:13] zero
  output logic [15:0]  m_axis_tdata
);

  logic [7:0]        phase_ticks_q;
  logic [7:0]        ack_timeout_q;
  logic              out_valid_q;
  i2cm_pkg::result_t res_q, res;
  i2cm_pkg::tick_t   tick;
  logic              accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign tick.cmd_valid = s_axis_tdata[0];
  assign tick.kind      = i2cm_pkg::kind_e'(s_axis_tuser);
  assign tick.tx_byte   = s_axis_tdata[8:1];
  assign tick.send_ack  = s_axis_tdata[9];
  assign tick.sda_level = s_axis_tdata[10];

  i2cm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .tick_i        (tick),
    .phase_ticks_i (phase_ticks_q),
    .ack_timeout_i (ack_timeout_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= i2cm_pkg::PhaseTicksRst;
      ack_timeout_q <= i2cm_pkg::AckTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        i2cm_pkg::CfgPhaseTicks: phase_ticks_q <= cfg_wdata_i;
        default:                 ack_timeout_q <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.status, res_q.rx_byte, res_q.done_res,
                          res_q.busy_res, res_q.sda_release, res_q.scl_release};

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.done_res && res_q.busy_res))
    else $error("done reported while still busy");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule

// ----- sim/tb_i2c_bit_level_master.sv -----
// ----------------------------------------------------------------------------
// tb_i2c_bit_level_master
// Self-checking bench for the I2C byte-level bus master.
// ----------------------------------------------------------------------------
// Bus ticks go in on the input stream and every tick is checked against a
// tick-accurate model of the sequencer kept in this file. A short table of
// commands runs first, with the shortest phases and an immediate ack
// timeout. Random command runs follow under several phase and timeout
// settings, the longest phase length among them. Both stream sides idle in
// random bursts, and once the receiver holds off long enough to back the
// block up. Completions are also checked against known outcomes where the
// table gives one.
module tb_i2c_bit_level_master;

  localparam int unsigned CycleLimit = 400_000;

  typedef enum logic [1:0] {
    LineRandom = 2'd0,
    LineLow    = 2'd1,
    LineHigh   = 2'd2
  } sda_plan_e;

  // known result of one command, looked at on its done pulse
  typedef struct packed {
    logic        chk;
    logic [7:0]  rx;
    logic        st;
  } outcome_t;

  localparam outcome_t NoOutcome = '0;

  typedef struct packed {
    i2cm_pkg::kind_e kind;
    logic [7:0]      tx;
    logic            sack;
    sda_plan_e       sda_plan;
    logic            noise;
    logic [1:0]      idle_after;
    outcome_t        want;
  } probe_row_t;

  localparam int NumProbes = 9;
  localparam probe_row_t Probes [NumProbes] = '{
    '{i2cm_pkg::KindStart, 8'h00, 1'b0, LineRandom, 1'b0, 2'd1, '{1'b1, 8'h00, 1'b0}},
    '{i2cm_pkg::KindSend,  8'h00, 1'b0, LineLow,    1'b0, 2'd0, '{1'b1, 8'h00, 1'b0}},
    // sda never pulled during ack: first high sample times out
    '{i2cm_pkg::KindSend,  8'hFF, 1'b0, LineHigh,   1'b0, 2'd1, '{1'b1, 8'h00, 1'b1}},
    // ACK driven, sda must stay pulled low through the idle ticks
    '{i2cm_pkg::KindRecv,  8'h00, 1'b1, LineHigh,   1'b0, 2'd2, '{1'b1, 8'hFF, 1'b0}},
    '{i2cm_pkg::KindRecv,  8'hFF, 1'b0, LineLow,    1'b0, 2'd0, '{1'b1, 8'h00, 1'b0}},
    '{i2cm_pkg::KindSend,  8'hA5, 1'b1, LineRandom, 1'b1, 2'd1, NoOutcome},
    '{i2cm_pkg::KindRecv,  8'h5A, 1'b1, LineRandom, 1'b1, 2'd3, NoOutcome},
    '{i2cm_pkg::KindSend,  8'h5A, 1'b0, LineLow,    1'b0, 2'd0, NoOutcome},
    '{i2cm_pkg::KindStop,  8'hC3, 1'b1, LineRandom, 1'b1, 2'd1, NoOutcome}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = i2cm_pkg::CfgPhaseTicks;
  logic [7:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [0] cmd_valid, [8:1] tx_byte, [9] send_ack, [10] sda_level, [15:11] zero
  logic [15:0] s_axis_tdata = '0;
  // [1:0] kind
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
  // [11:4] rx_byte, [12] status, [15:13] zero
  logic [15:0] m_axis_tdata;

  i2c_bit_level_master dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // sequencer model state and its copy of the registers
  i2cm_pkg::seq_state_t bus;
  logic [7:0]  cfg_pt;
  logic [7:0]  cfg_at;

  i2cm_pkg::result_t line_levels_q [$];
  outcome_t    cmd_outcome_q [$];
  int          mismatch_n = 0;
  int          tick_n = 0;
  int unsigned cycle_n = 0;
  int          gap_odds = 4;
  logic        quiet = 1'b0;
  logic        hold_off_req = 1'b0;
  logic        hold_off_done = 1'b0;

  function automatic void enter_phase(i2cm_pkg::phase_e p, logic scl, logic sda);
    bus.phase       = p;
    bus.scl         = scl;
    bus.sda         = sda;
    bus.delay_count = '0;
  endfunction

  // end of a timed phase; returns 1 when the command is complete
  function automatic logic leave_phase();
    case (bus.phase)
      i2cm_pkg::PhStA: enter_phase(i2cm_pkg::PhStB, bus.scl, 1'b0);
      i2cm_pkg::PhStB: enter_phase(i2cm_pkg::PhStC, 1'b0, bus.sda);
      i2cm_pkg::PhSpA: enter_phase(i2cm_pkg::PhSpB, 1'b1, 1'b1);
      i2cm_pkg::PhTxA: enter_phase(i2cm_pkg::PhTxB, 1'b1, bus.sda);
      i2cm_pkg::PhTxB: begin
        bus.shift_reg = bus.shift_reg << 1;
        bus.bit_count = bus.bit_count + 4'd1;
        enter_phase(i2cm_pkg::PhTxC, 1'b0, 1'b1);
      end
      i2cm_pkg::PhTxC: begin
        if (bus.bit_count >= i2cm_pkg::BitsPerByte)
          enter_phase(i2cm_pkg::PhAkA, bus.scl, 1'b1);
        else enter_phase(i2cm_pkg::PhTxA, 1'b0, bus.shift_reg[7]);
      end
      i2cm_pkg::PhAkA: enter_phase(i2cm_pkg::PhAkB, 1'b1, bus.sda);
      i2cm_pkg::PhAkB: begin
        bus.wait_count = '0;
        enter_phase(i2cm_pkg::PhAkW, bus.scl, bus.sda);
      end
      i2cm_pkg::PhRxL: begin
        if (bus.ack_drive) begin
          bus.ack_drive = 1'b0;
          enter_phase(i2cm_pkg::PhRaB, 1'b1, bus.sda);
        end else begin
          enter_phase(i2cm_pkg::PhRxH, 1'b1, bus.sda);
        end
      end
      i2cm_pkg::PhRxH: begin
        bus.bit_count = bus.bit_count + 4'd1;
        if (bus.bit_count >= i2cm_pkg::BitsPerByte) begin
          bus.ack_drive = 1'b1;
          enter_phase(i2cm_pkg::PhRxL, 1'b0, !bus.ack_choice);
        end else begin
          enter_phase(i2cm_pkg::PhRxL, 1'b0, bus.sda);
        end
      end
      i2cm_pkg::PhRaB: begin
        bus.scl         = 1'b0;
        bus.phase       = i2cm_pkg::PhIdle;
        bus.delay_count = '0;
        return 1'b1;
      end
      i2cm_pkg::PhStC, i2cm_pkg::PhSpB, i2cm_pkg::PhAkD: begin
        bus.phase       = i2cm_pkg::PhIdle;
        bus.delay_count = '0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic i2cm_pkg::result_t sequence_tick(i2cm_pkg::tick_t t);
    logic [8:0]        pt;
    logic              fin;
    i2cm_pkg::result_t r;
    pt  = (cfg_pt == 8'd0) ? 9'd1 : {1'b0, cfg_pt};
    fin = 1'b0;
    if (bus.phase == i2cm_pkg::PhIdle) begin
      if (t.cmd_valid) begin
        bus.ack_status = 1'b0;
        bus.wait_count = '0;
        bus.bit_count  = '0;
        bus.ack_drive  = 1'b0;
        case (t.kind)
          i2cm_pkg::KindStart: enter_phase(i2cm_pkg::PhStA, 1'b1, 1'b1);
          i2cm_pkg::KindSend: begin
            bus.shift_reg = t.tx_byte;
            enter_phase(i2cm_pkg::PhTxA, 1'b0, t.tx_byte[7]);
          end
          i2cm_pkg::KindRecv: begin
            bus.received   = '0;
            bus.ack_choice = t.send_ack;
            enter_phase(i2cm_pkg::PhRxL, 1'b0, 1'b1);
          end
          default: enter_phase(i2cm_pkg::PhSpA, 1'b0, 1'b0);
        endcase
      end
    end else if (bus.phase == i2cm_pkg::PhAkW) begin
      if (!t.sda_level) begin
        enter_phase(i2cm_pkg::PhAkD, 1'b0, bus.sda);
      end else if (bus.wait_count >= cfg_at) begin
        bus.ack_status = 1'b1;
        enter_phase(i2cm_pkg::PhSpA, 1'b0, 1'b0);
      end else begin
        bus.wait_count = bus.wait_count + 8'd1;
      end
    end else begin
      // bit is sampled on the first tick of the scl-high phase
      if (bus.phase == i2cm_pkg::PhRxH && bus.delay_count == 8'd0)
        bus.received = {bus.received[6:0], t.sda_level};
      if ({1'b0, bus.delay_count} + 9'd1 >= pt) fin = leave_phase();
      else bus.delay_count = bus.delay_count + 8'd1;
    end
    r.scl_release = bus.scl;
    r.sda_release = bus.sda;
    r.busy_res    = (bus.phase != i2cm_pkg::PhIdle);
    r.done_res    = fin;
    r.rx_byte     = bus.received;
    r.status      = bus.ack_status;
    return r;
  endfunction

  function automatic logic sda_for(sda_plan_e plan);
    if (plan == LineLow) return 1'b0;
    if (plan == LineHigh) return 1'b1;
    // mostly high while waiting for ack so that waits run a few ticks
    if (bus.phase == i2cm_pkg::PhAkW) return ($urandom_range(0, 3) != 0);
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_n++;
    end
  endfunction

  task automatic put_tick(i2cm_pkg::tick_t t, outcome_t oc);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, t.sda_level, t.send_ack, t.tx_byte, t.cmd_valid};
    s_axis_tuser  <= t.kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (bus.phase != i2cm_pkg::PhIdle || t.cmd_valid) tick_n++;
    if (t.cmd_valid && bus.phase == i2cm_pkg::PhIdle) cmd_outcome_q.push_back(oc);
    line_levels_q.push_back(sequence_tick(t));
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic idle_tick();
    i2cm_pkg::tick_t t;
    t.cmd_valid = 1'b0;
    t.kind      = i2cm_pkg::kind_e'($urandom_range(0, 3));
    t.tx_byte   = 8'($urandom);
    t.send_ack  = 1'($urandom);
    t.sda_level = 1'($urandom);
    put_tick(t, NoOutcome);
  endtask

  // one command from idle back to idle, optionally with commands offered
  // while busy, which the block must ignore
  task automatic run_command(i2cm_pkg::kind_e k, logic [7:0] tx, logic sack,
                             sda_plan_e plan, logic noise, outcome_t oc);
    i2cm_pkg::tick_t t;
    t.cmd_valid = 1'b1;
    t.kind      = k;
    t.tx_byte   = tx;
    t.send_ack  = sack;
    t.sda_level = sda_for(plan);
    put_tick(t, oc);
    while (bus.phase != i2cm_pkg::PhIdle) begin
      t.cmd_valid = noise && ($urandom_range(0, 3) == 0);
      t.kind      = i2cm_pkg::kind_e'($urandom_range(0, 3));
      t.tx_byte   = 8'($urandom);
      t.send_ack  = 1'($urandom);
      t.sda_level = sda_for(plan);
      put_tick(t, NoOutcome);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (line_levels_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [7:0] pt, logic [7:0] at);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= i2cm_pkg::CfgPhaseTicks;
    cfg_wdata_i <= pt;
    @(posedge clk_i);
    cfg_idx_i   <= i2cm_pkg::CfgAckTimeout;
    cfg_wdata_i <= at;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_pt = pt;
    cfg_at = at;
  endtask

  task automatic run_phase(logic [7:0] pt, logic [7:0] at, int ticks, logic slow);
    int              first_n;
    i2cm_pkg::kind_e k;
    sda_plan_e       plan;
    settle();
    write_cfg(pt, at);
    gap_odds = ($urandom_range(0, 1) != 0) ? 4 : 10;
    first_n  = tick_n;
    k        = i2cm_pkg::KindStop;
    while (tick_n - first_n < ticks) begin
      if (!slow) k = i2cm_pkg::kind_e'($urandom_range(0, 3));
      else if (k == i2cm_pkg::KindStart) k = i2cm_pkg::KindStop;
      else k = i2cm_pkg::KindStart;
      case ($urandom_range(0, 7))
        0: plan = LineHigh;
        1: plan = LineLow;
        default: plan = LineRandom;
      endcase
      run_command(k, 8'($urandom), 1'($urandom), plan, $urandom_range(0, 2) == 0,
                  NoOutcome);
      repeat ($urandom_range(0, 3)) idle_tick();
    end
  endtask

  // receiver: bursts of ready, bursts of stall, one long hold-off
  initial begin : sink_side
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        m_axis_tready <= 1'b0;
        hold_off_done = 1'b1;
        repeat (300) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(0, 39)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    i2cm_pkg::result_t want;
    outcome_t          oc;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (line_levels_q.size() == 0) begin
        $error("result transaction with nothing expected: %h", m_axis_tdata);
        mismatch_n++;
      end else begin
        want = line_levels_q.pop_front();
        check_field("scl_release", 8'(want.scl_release), 8'(m_axis_tdata[0]));
        check_field("sda_release", 8'(want.sda_release), 8'(m_axis_tdata[1]));
        check_field("busy_res", 8'(want.busy_res), 8'(m_axis_tdata[2]));
        check_field("done_res", 8'(want.done_res), 8'(m_axis_tdata[3]));
        check_field("rx_byte", want.rx_byte, m_axis_tdata[11:4]);
        check_field("status", 8'(want.status), 8'(m_axis_tdata[12]));
      end
      if (m_axis_tdata[3]) begin
        if (cmd_outcome_q.size() == 0) begin
          $error("done pulse with no command in flight");
          mismatch_n++;
        end else begin
          oc = cmd_outcome_q.pop_front();
          if (oc.chk) begin
            check_field("rx_byte on done", oc.rx, m_axis_tdata[11:4]);
            check_field("status on done", 8'(oc.st), 8'(m_axis_tdata[12]));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_n++;
    if (cycle_n > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    bus            = '0;
    bus.phase      = i2cm_pkg::PhIdle;
    bus.scl        = 1'b1;
    bus.sda        = 1'b1;
    cfg_pt         = i2cm_pkg::PhaseTicksRst;
    cfg_at         = i2cm_pkg::AckTimeoutRst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // phase length zero acts as one, timeout zero gives up on first high
    settle();
    write_cfg(8'd0, 8'd0);
    gap_odds = 3;
    for (int i = 0; i < NumProbes; i++) begin
      run_command(Probes[i].kind, Probes[i].tx, Probes[i].sack, Probes[i].sda_plan,
                  Probes[i].noise, Probes[i].want);
      repeat (Probes[i].idle_after) idle_tick();
    end

    hold_off_req = 1'b1;
    run_phase(8'd1, 8'd1, 180, 1'b0);
    run_phase(8'd2, 8'($urandom_range(0, 7)), 180, 1'b0);
    run_phase(8'($urandom_range(1, 3)), 8'd255, 180, 1'b0);
    // longest phases: one start condition only
    run_phase(8'd255, 8'($urandom_range(1, 254)), 1, 1'b1);
    quiet = 1'b1;
    run_phase(8'($urandom_range(1, 4)), 8'($urandom_range(0, 255)), 180, 1'b0);

    settle();
    repeat (4) @(posedge clk_i);
    if (cmd_outcome_q.size() != 0) begin
      $error("%0d commands never completed", cmd_outcome_q.size());
      mismatch_n++;
    end
    if (mismatch_n == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- i2c_bit_level_master.f -----
src/i2cm_pkg.sv
src/i2cm_seq.sv
src/i2c_bit_level_master.sv
sim/tb_i2c_bit_level_master.sv
